@@ sv/cseq_pkg.sv @@
package cseq_pkg;

    // Buffer geometry and field widths.
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;

    // Command codes.
    localparam logic [REQ_W-1:0] REQ_START   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ATTACH  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_REWIND,
        S_EXEC,
        S_REPORT
    } t_state;

    // Datapath operations on the two stacks.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_STEP_BACK,
        OP_STEP_FWD,
        OP_PUSH,
        OP_ATTACH,
        OP_POP
    } t_dp_op;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic has_cur;
        logic full;
        logic left_empty;
    } t_dp_status;

endpackage

@@ sv/cursor_sequence_buffer.sv @@
// Channel   Direction  Handshake                     Payload
// command   in         start high while busy low     i_req_type, i_entry_value
// result    out        o_result_valid, one cycle     o_status, o_has_current,
//                                                    o_current_value, o_item_count,
//                                                    o_cursor_pos
//
// After the cycle a command is accepted in, the controller enters its execute state,
// and the result strobe is raised in the cycle after it.
// Start, and an insert with no current item and room to spare, first pass through a
// rewind state that moves one item a cycle between the two stacks to empty the left one.
// The next command is accepted in the cycle after the result strobe.
// Reset is synchronous and active low; it empties the buffer and sets the cursor
// to the front. Stored words need no reset. The receiver cannot stall results.
module cursor_sequence_buffer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [cseq_pkg::REQ_W-1:0]       i_req_type,
    input  logic [cseq_pkg::DATA_WIDTH-1:0]  i_entry_value,
    output logic                             o_result_valid,
    output logic [cseq_pkg::STATUS_W-1:0]    o_status,
    output logic                             o_has_current,
    output logic [cseq_pkg::DATA_WIDTH-1:0]  o_current_value,
    output logic [cseq_pkg::CNT_W-1:0]       o_item_count,
    output logic [cseq_pkg::CNT_W-1:0]       o_cursor_pos
);
    import cseq_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencing of each transaction.
    cseq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_req_type     (i_req_type),
        .i_dp_status    (dp_status),
        .o_cmd          (dp_cmd),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_status       (o_status)
    );

    // Two cell stacks that hold the buffer around the cursor.
    cseq_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_entry_value   (i_entry_value),
        .o_status        (dp_status),
        .o_has_current   (o_has_current),
        .o_current_value (o_current_value),
        .o_item_count    (o_item_count),
        .o_cursor_pos    (o_cursor_pos)
    );

endmodule

@@ sv/cseq_datapath.sv @@
module cseq_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cseq_pkg::t_dp_cmd                i_cmd,
    input  logic [cseq_pkg::DATA_WIDTH-1:0]  i_entry_value,
    output cseq_pkg::t_dp_status             o_status,
    output logic                             o_has_current,
    output logic [cseq_pkg::DATA_WIDTH-1:0]  o_current_value,
    output logic [cseq_pkg::CNT_W-1:0]       o_item_count,
    output logic [cseq_pkg::CNT_W-1:0]       o_cursor_pos
);
    import cseq_pkg::*;

    // The left stack holds the items before the cursor, its top being the item
    // just before it. The right stack holds the current item and those after it,
    // its top being the current item.
    logic [DATA_WIDTH-1:0] r_left  [CAPACITY];
    logic [DATA_WIDTH-1:0] r_right [CAPACITY];
    logic [CNT_W-1:0]      r_lsize;
    logic [CNT_W-1:0]      r_rsize;
    logic [DATA_WIDTH-1:0] r_word;
    logic [CNT_W-1:0]      total;

    logic                  left_push;
    logic                  left_pop;
    logic [DATA_WIDTH-1:0] left_src;
    logic                  right_push;
    logic                  right_pop;
    logic                  right_replace;
    logic [DATA_WIDTH-1:0] right_src;

    // Decode the operation into stack moves.
    always_comb begin
        left_push     = 1'b0;
        left_pop      = 1'b0;
        left_src      = r_right[0];
        right_push    = 1'b0;
        right_pop     = 1'b0;
        right_replace = 1'b0;
        right_src     = r_word;
        unique case (i_cmd.op)
            OP_STEP_BACK: begin
                right_push = 1'b1;
                right_src  = r_left[0];
                left_pop   = 1'b1;
            end
            OP_STEP_FWD: begin
                left_push = 1'b1;
                right_pop = 1'b1;
            end
            OP_PUSH: begin
                right_push = 1'b1;
            end
            OP_ATTACH: begin
                left_push     = 1'b1;
                right_replace = 1'b1;
            end
            OP_POP: begin
                right_pop = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Latch the data word of a new transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_entry_value;
        end
    end

    // Left stack cells: each cell takes its neighbor on a push or a pop.
    always_ff @(posedge i_clk) begin
        if (left_push) begin
            r_left[0] <= left_src;
            for (int i = 1; i < CAPACITY; i++) begin
                r_left[i] <= r_left[i-1];
            end
        end else if (left_pop) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                r_left[i] <= r_left[i+1];
            end
        end
    end

    // Right stack cells.
    always_ff @(posedge i_clk) begin
        if (right_push) begin
            r_right[0] <= right_src;
            for (int i = 1; i < CAPACITY; i++) begin
                r_right[i] <= r_right[i-1];
            end
        end else if (right_pop) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                r_right[i] <= r_right[i+1];
            end
        end else if (right_replace) begin
            r_right[0] <= right_src;
        end
    end

    // Stack depths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsize <= '0;
            r_rsize <= '0;
        end else begin
            if (left_push) begin
                r_lsize <= r_lsize + 1'b1;
            end else if (left_pop) begin
                r_lsize <= r_lsize - 1'b1;
            end
            if (right_push) begin
                r_rsize <= r_rsize + 1'b1;
            end else if (right_pop) begin
                r_rsize <= r_rsize - 1'b1;
            end
        end
    end

    assign total = r_lsize + r_rsize;

    // Status toward the controller and result fields.
    assign o_status.has_cur    = (r_rsize != '0);
    assign o_status.full       = (total == CNT_W'(CAPACITY));
    assign o_status.left_empty = (r_lsize == '0);

    assign o_has_current   = (r_rsize != '0);
    assign o_current_value = (r_rsize != '0) ? r_right[0] : '0;
    assign o_item_count    = total;
    assign o_cursor_pos    = r_lsize;

    // The buffer never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (total <= CNT_W'(CAPACITY)))
        else $error("item count above capacity");

    // A push adds exactly one item to the right stack.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_PUSH) |=> (r_rsize == $past(r_rsize) + 1'b1))
        else $error("push did not grow the right stack");

    // Moving the cursor forward or back keeps the item count.
    a_step_keeps_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_STEP_FWD || i_cmd.op == OP_STEP_BACK) |=> $stable(total))
        else $error("cursor step changed the item count");

endmodule

@@ sv/cseq_ctrl.sv @@
module cseq_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [cseq_pkg::REQ_W-1:0]       i_req_type,
    input  cseq_pkg::t_dp_status             i_dp_status,
    output cseq_pkg::t_dp_cmd                o_cmd,
    output logic                             busy,
    output logic                             o_result_valid,
    output logic [cseq_pkg::STATUS_W-1:0]    o_status
);
    import cseq_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [REQ_W-1:0]      r_req;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;
    logic                  need_rewind;
    logic                  accept;

    assign accept = start && (r_state == S_IDLE);

    // Check a new command against the current buffer state.
    always_comb begin
        n_status = ST_OK;
        if ((i_req_type == REQ_INSERT || i_req_type == REQ_ATTACH) && i_dp_status.full) begin
            n_status = ST_FULL;
        end else if (i_req_type == REQ_REMOVE && !i_dp_status.has_cur) begin
            n_status = ST_EMPTY;
        end
        need_rewind = (i_req_type == REQ_START)
                   || (i_req_type == REQ_INSERT && !i_dp_status.has_cur
                       && !i_dp_status.full);
    end

    // Command and status registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_req    <= REQ_START;
            r_status <= ST_OK;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_req    <= i_req_type;
                r_status <= n_status;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = need_rewind ? S_REWIND : S_EXEC;
                end
            end
            S_REWIND: begin
                if (i_dp_status.left_empty) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_REPORT;
            end
            S_REPORT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_cmd.load     = 1'b0;
        o_cmd.op       = OP_NONE;
        busy           = 1'b1;
        o_result_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_REWIND: begin
                if (!i_dp_status.left_empty) begin
                    o_cmd.op = OP_STEP_BACK;
                end
            end
            S_EXEC: begin
                unique case (r_req)
                    REQ_ADVANCE: begin
                        if (i_dp_status.has_cur) begin
                            o_cmd.op = OP_STEP_FWD;
                        end
                    end
                    REQ_INSERT: begin
                        if (r_status == ST_OK) begin
                            o_cmd.op = OP_PUSH;
                        end
                    end
                    REQ_ATTACH: begin
                        if (r_status == ST_OK) begin
                            o_cmd.op = i_dp_status.has_cur ? OP_ATTACH : OP_PUSH;
                        end
                    end
                    REQ_REMOVE: begin
                        if (r_status == ST_OK) begin
                            o_cmd.op = OP_POP;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_REPORT: begin
                o_result_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_status = r_status;

    // A result follows the execute cycle.
    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_EXEC))
        else $error("result strobe without execute cycle");

    // The controller is free again right after a result.
    a_free_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !busy)
        else $error("busy after result");

    // A rewind leaves the cursor at the front.
    a_rewind_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REWIND && n_state == S_EXEC) |-> i_dp_status.left_empty)
        else $error("rewind left items before the cursor");

endmodule

@@ tb/cseq_checker.sv @@
module cseq_checker
    import cseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [DATA_WIDTH-1:0] i_entry_value,
    input  logic                  i_result_valid,
    input  logic [STATUS_W-1:0]   i_status,
    input  logic                  i_has_current,
    input  logic [DATA_WIDTH-1:0] i_current_value,
    input  logic [CNT_W-1:0]      i_item_count,
    input  logic [CNT_W-1:0]      i_cursor_pos,
    output int                    o_mismatch_count,
    output int                    o_outstanding
);

    // One result as the block should report it.
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic                  has_current;
        logic [DATA_WIDTH-1:0] current_value;
        logic [CNT_W-1:0]      item_count;
        logic [CNT_W-1:0]      cursor_pos;
    } t_report;

    // Shadow copy of the buffer contents, its length and the cursor.
    logic [DATA_WIDTH-1:0] seq_words [CAPACITY];
    int unsigned           word_count;
    int unsigned           cursor_idx;

    // Reports predicted for accepted commands, oldest first.
    t_report awaited_reports [$];
    int      mismatch_total;

    initial begin
        word_count       = 0;
        cursor_idx       = 0;
        mismatch_total   = 0;
        o_mismatch_count = 0;
        o_outstanding    = 0;
    end

    // Applies one command to the shadow buffer and returns the report it causes.
    function automatic t_report apply_command(input logic [REQ_W-1:0] req,
                                              input logic [DATA_WIDTH-1:0] word);
        t_report     rep;
        logic        has_cur;
        int unsigned pos;
        int unsigned i;
        rep.status = ST_OK;
        has_cur    = cursor_idx < word_count;
        case (req)
            REQ_START: begin
                cursor_idx = 0;
            end
            REQ_ADVANCE: begin
                if (has_cur) begin
                    cursor_idx = cursor_idx + 1;
                end
            end
            REQ_INSERT, REQ_ATTACH: begin
                if (word_count >= CAPACITY) begin
                    rep.status = ST_FULL;
                end else begin
                    if (req == REQ_INSERT) begin
                        pos = has_cur ? cursor_idx : 0;
                    end else begin
                        pos = has_cur ? cursor_idx + 1 : word_count;
                    end
                    for (i = word_count; i > pos; i--) begin
                        seq_words[i] = seq_words[i - 1];
                    end
                    seq_words[pos] = word;
                    word_count     = word_count + 1;
                    cursor_idx     = pos;
                end
            end
            REQ_REMOVE: begin
                if (!has_cur) begin
                    rep.status = ST_EMPTY;
                end else begin
                    // Later words slide down; the follower becomes current.
                    for (i = cursor_idx; i + 1 < word_count; i++) begin
                        seq_words[i] = seq_words[i + 1];
                    end
                    word_count = word_count - 1;
                end
            end
            default: begin
                // Unused codes leave the buffer untouched.
            end
        endcase
        rep.has_current   = cursor_idx < word_count;
        rep.current_value = rep.has_current ? seq_words[cursor_idx] : '0;
        rep.item_count    = CNT_W'(word_count);
        rep.cursor_pos    = CNT_W'(cursor_idx);
        return rep;
    endfunction

    // Counts a bad result and describes the first few of them.
    task automatic flag_mismatch(input string what, input t_report want,
                                 input t_report got);
        mismatch_total = mismatch_total + 1;
        if (mismatch_total <= 10) begin
            $display("cseq mismatch at %0t: %s", $realtime, what);
            $display("  expected status=%0d cur=%0b value=%h count=%0d pos=%0d",
                     want.status, want.has_current, want.current_value,
                     want.item_count, want.cursor_pos);
            $display("  actual   status=%0d cur=%0b value=%h count=%0d pos=%0d",
                     got.status, got.has_current, got.current_value,
                     got.item_count, got.cursor_pos);
        end
    endtask

    // Check each result against the oldest prediction, then predict for any
    // transaction accepted at this edge.
    always @(posedge i_clk) begin : watch
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            word_count = 0;
            cursor_idx = 0;
            awaited_reports.delete();
        end else begin
            if (i_result_valid) begin
                got = {i_status, i_has_current, i_current_value, i_item_count,
                       i_cursor_pos};
                if (awaited_reports.size() == 0) begin
                    flag_mismatch("result with no command outstanding", '0, got);
                end else begin
                    want = awaited_reports.pop_front();
                    if (got != want) begin
                        flag_mismatch("result differs from prediction", want, got);
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_reports.push_back(apply_command(i_req_type, i_entry_value));
            end
        end
        o_outstanding    <= awaited_reports.size();
        o_mismatch_count <= mismatch_total;
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    import cseq_pkg::*;

    // Codes the block does not define; it must ignore them.
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    localparam int RANDOM_ITEMS = 850;
    localparam int PHASES       = 4;
    localparam int MAX_GAP      = 24;
    localparam int DRAIN_CYCLES = 3 * CAPACITY;
    localparam int CYCLE_LIMIT  = 600000;

    // Random stretches lean toward growing, shrinking or a blend of commands.
    typedef enum logic [1:0] {
        BURST_FILL,
        BURST_DRAIN,
        BURST_BLEND
    } t_burst;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cmd_start;
    logic                  cmd_busy;
    logic [REQ_W-1:0]      cmd_req;
    logic [DATA_WIDTH-1:0] cmd_value;
    logic                  res_valid;
    logic [STATUS_W-1:0]   res_status;
    logic                  res_has_cur;
    logic [DATA_WIDTH-1:0] res_value;
    logic [CNT_W-1:0]      res_count;
    logic [CNT_W-1:0]      res_cursor;
    int                    mismatch_count;
    int                    outstanding;
    int                    idle_pct;
    int                    cycle_count;

    cursor_sequence_buffer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (cmd_start),
        .busy            (cmd_busy),
        .i_req_type      (cmd_req),
        .i_entry_value   (cmd_value),
        .o_result_valid  (res_valid),
        .o_status        (res_status),
        .o_has_current   (res_has_cur),
        .o_current_value (res_value),
        .o_item_count    (res_count),
        .o_cursor_pos    (res_cursor)
    );

    cseq_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (cmd_start),
        .i_busy           (cmd_busy),
        .i_req_type       (cmd_req),
        .i_entry_value    (cmd_value),
        .i_result_valid   (res_valid),
        .i_status         (res_status),
        .i_has_current    (res_has_cur),
        .i_current_value  (res_value),
        .i_item_count     (res_count),
        .i_cursor_pos     (res_cursor),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = ~i_clk;
    end

    // Watchdog against a hung handshake.
    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Presents one transaction at the falling edge, after an optional random
    // gap, and returns at the falling edge after it has been accepted.
    task automatic send_command(input logic [REQ_W-1:0] req,
                                input logic [DATA_WIDTH-1:0] value);
        int gap;
        bit taken;
        gap = 0;
        while (idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
            cmd_start = 1'b0;
            cmd_req   = REQ_W'($urandom());
            cmd_value = $urandom();
            gap       = gap + 1;
            @(negedge i_clk);
        end
        cmd_start = 1'b1;
        cmd_req   = req;
        cmd_value = value;
        taken     = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !cmd_busy;
            @(negedge i_clk);
        end
    endtask

    // Draws a command code according to the current stretch.
    function automatic logic [REQ_W-1:0] pick_request(input t_burst burst);
        int roll;
        roll = $urandom_range(99);
        case (burst)
            BURST_FILL: begin
                if (roll < 45) return REQ_INSERT;
                if (roll < 85) return REQ_ATTACH;
                if (roll < 93) return REQ_ADVANCE;
                if (roll < 97) return REQ_START;
                return REQ_REMOVE;
            end
            BURST_DRAIN: begin
                if (roll < 55) return REQ_REMOVE;
                if (roll < 75) return REQ_ADVANCE;
                if (roll < 90) return REQ_START;
                if (roll < 95) return REQ_INSERT;
                return REQ_ATTACH;
            end
            default: begin
                if (roll < 20) return REQ_INSERT;
                if (roll < 40) return REQ_ATTACH;
                if (roll < 60) return REQ_ADVANCE;
                if (roll < 72) return REQ_START;
                if (roll < 92) return REQ_REMOVE;
                return REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
            end
        endcase
    endfunction

    // Stimulus and verdict.
    initial begin : stimulus
        int     phase;
        int     sent;
        int     burst_left;
        int     roll;
        t_burst burst;

        cmd_start = 1'b0;
        cmd_req   = REQ_START;
        cmd_value = '0;
        idle_pct  = 0;
        i_rst_n   = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed walk through the corner cases, starting from an empty buffer.
        send_command(REQ_ADVANCE, '0);
        send_command(REQ_REMOVE, '0);
        send_command(REQ_START, '1);
        send_command(REQ_INSERT, 32'h0000_0000);
        send_command(REQ_ATTACH, 32'hFFFF_FFFF);
        send_command(REQ_ADVANCE, '0);
        send_command(REQ_ADVANCE, '0);
        send_command(REQ_ATTACH, 32'hA5A5_A5A5);
        send_command(REQ_START, '0);
        send_command(REQ_INSERT, 32'h5A5A_5A5A);
        send_command(REQ_ADVANCE, '0);
        send_command(REQ_REMOVE, '0);
        send_command(REQ_ADVANCE, '0);
        send_command(REQ_REMOVE, '0);
        send_command(REQ_INSERT, 32'h1234_5678);
        send_command(REQ_UNUSED_LO, $urandom());
        send_command(REQ_UNUSED_LO + 3'd1, $urandom());
        send_command(REQ_UNUSED_HI, $urandom());
        send_command(REQ_REMOVE, '0);
        send_command(REQ_START, '0);

        // Random stretches; the idle rate changes from phase to phase.
        for (phase = 0; phase < PHASES; phase++) begin
            idle_pct   = (phase == 1) ? 74 : (phase == 3) ? 18 : 0;
            sent       = 0;
            burst_left = 0;
            burst      = BURST_FILL;
            while (sent < RANDOM_ITEMS / PHASES) begin
                if (burst_left == 0) begin
                    roll       = $urandom_range(99);
                    burst      = (roll < 30) ? BURST_FILL :
                                 (roll < 55) ? BURST_DRAIN : BURST_BLEND;
                    burst_left = $urandom_range(90, 30);
                end
                send_command(pick_request(burst), $urandom());
                burst_left = burst_left - 1;
                sent       = sent + 1;
            end
        end

        // Let the last results arrive, then a quiet tail.
        cmd_start = 1'b0;
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/cseq_pkg.sv
sv/cseq_datapath.sv
sv/cseq_ctrl.sv
sv/cursor_sequence_buffer.sv
tb/cseq_checker.sv
tb/testbench.sv
